// File: hw/rtl/idel_pkg.sv
// shared types and codes for the indexed double-ended list
package idel_pkg;

   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_INSERT     = 3'd4,
      OP_ERASE      = 3'd5,
      OP_DUMP       = 3'd6,
      OP_RDUMP      = 3'd7
   } opcode_type;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_IGNORED = 2'd1,
      ST_FULL    = 2'd2,
      ST_SPARE   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_WALK,
      BK_READP,
      BK_LINK,
      BK_DUMP,
      BK_RESULT
   } back_state_type;

   localparam int unsigned POS_BITS = 6;
   localparam int unsigned CNT_BITS = 7;
   localparam int unsigned OUT_BITS = 32;

   typedef struct packed {
      opcode_type           opcode;
      logic [POS_BITS-1:0]  position;
      logic [OUT_BITS-1:0]  item_value;
   } cmd_type;

endpackage

// File: hw/rtl/idel_queue.sv
// two-entry command queue between the front and the back
module idel_queue
   import idel_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_valid,
   output logic    wr_stall,
   input  cmd_type wr_cmd,
   output logic    rd_valid,
   input  logic    rd_take,
   output cmd_type rd_cmd
);

   cmd_type    mem_ff [2];
   logic       wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_wr, do_rd;

   assign wr_stall = (cnt_ff == 2'd2);
   assign rd_valid = (cnt_ff != 2'd0);
   assign rd_cmd   = mem_ff[rptr_ff];
   assign do_wr    = wr_valid && !wr_stall;
   assign do_rd    = rd_take && rd_valid;

   always_comb begin
      wptr_in = do_wr ? ~wptr_ff : wptr_ff;
      rptr_in = do_rd ? ~rptr_ff : rptr_ff;
      cnt_in  = cnt_ff + {1'b0, do_wr} - {1'b0, do_rd};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wptr_ff] <= wr_cmd;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> !do_wr) else $error("queue overflow");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("queue count out of range");
   a_empty_no_read: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd0 |-> !do_rd) else $error("queue underflow");
`endif

endmodule

// File: hw/rtl/idel_back.sv
// list engine: link stores, position walk, updates and dumps
module idel_back
   import idel_pkg::*;
#(
   parameter int unsigned CAPACITY  = 32,
   parameter int unsigned WORD_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   output logic                 cmd_take,
   input  cmd_type              cmd,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_status,
   output logic [CNT_BITS-1:0]  rsp_entry_count,
   output logic [OUT_BITS-1:0]  rsp_dump_value,
   output logic                 rsp_last_of_run
);

   localparam int unsigned SB = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned CB = $clog2(CAPACITY + 1);

   logic [WORD_BITS-1:0] val_mem [CAPACITY];
   logic [SB-1:0]        nxt_mem [CAPACITY];
   logic [SB-1:0]        prv_mem [CAPACITY];

   back_state_type state_ff, state_in;
   cmd_type        c_ff, c_in;
   logic [SB-1:0]  head_ff, head_in, tail_ff, tail_in, t_ff, t_in, p_ff, p_in;
   logic [CB-1:0]  cnt_ff, cnt_in, steps_ff, steps_in;
   logic [CAPACITY-1:0] used_ff, used_in;
   logic           dir_ff, dir_in;

   logic           ov_ff, ov_in, olast_ff, olast_in;
   logic [1:0]     ost_ff, ost_in;
   logic [CNT_BITS-1:0] ocnt_ff, ocnt_in;
   logic [OUT_BITS-1:0] oval_ff, oval_in;

   logic [SB-1:0]  free_slot;
   logic [CB-1:0]  pos_c, half;
   logic           full, out_free;
   logic [OUT_BITS-1:0] ext_word;

   // memory write requests
   logic          vw_en, nw_en, pw_en, nw2_en, pw2_en;
   logic [SB-1:0] vw_a, nw_a, nw_d, pw_a, pw_d, nw2_a, nw2_d, pw2_a, pw2_d;

   always_comb begin
      free_slot = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (!used_ff[i]) free_slot = SB'(i);
      end
   end

   assign pos_c    = ({1'b0, cmd.position} >= CNT_BITS'(CAPACITY)) ? CB'(CAPACITY)
                                                                  : CB'(cmd.position);
   assign half     = cnt_ff >> 1;
   assign full     = (cnt_ff == CB'(CAPACITY));
   assign out_free = !ov_ff || !rsp_stall;
   assign ext_word = OUT_BITS'($signed(val_mem[t_ff]));

   assign rsp_valid       = ov_ff;
   assign rsp_status      = ost_ff;
   assign rsp_entry_count = ocnt_ff;
   assign rsp_dump_value  = oval_ff;
   assign rsp_last_of_run = olast_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid && out_free) begin
               priority if ((cmd.opcode == OP_INSERT || cmd.opcode == OP_ERASE)
                            && pos_c < cnt_ff && pos_c != '0 && !(cmd.opcode == OP_INSERT && full)
                            && !(cmd.opcode == OP_ERASE && pos_c + 1'b1 == cnt_ff)) begin
                  state_in = BK_WALK;
               end else if ((cmd.opcode == OP_DUMP || cmd.opcode == OP_RDUMP) && cnt_ff != '0) begin
                  state_in = BK_DUMP;
               end else begin
                  state_in = BK_IDLE;
               end
            end
         end
         BK_WALK:   if (steps_ff == '0) state_in = BK_READP;
         BK_READP:  state_in = BK_LINK;
         BK_LINK:   state_in = BK_RESULT;
         BK_RESULT: if (out_free) state_in = BK_IDLE;
         BK_DUMP:   if (out_free && steps_ff == CB'(1)) state_in = BK_IDLE;
         default:   state_in = BK_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      c_in = c_ff; head_in = head_ff; tail_in = tail_ff; t_in = t_ff; p_in = p_ff;
      cnt_in = cnt_ff; steps_in = steps_ff; used_in = used_ff; dir_in = dir_ff;
      ov_in = ov_ff && rsp_stall; ost_in = ost_ff; ocnt_in = ocnt_ff;
      oval_in = oval_ff; olast_in = olast_ff; cmd_take = 1'b0;
      vw_en = 1'b0; nw_en = 1'b0; pw_en = 1'b0; nw2_en = 1'b0; pw2_en = 1'b0;
      vw_a = free_slot; nw_a = '0; nw_d = '0; pw_a = '0; pw_d = '0;
      nw2_a = '0; nw2_d = '0; pw2_a = '0; pw2_d = '0;
      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_take = 1'b1;
               c_in = cmd;
               ov_in = 1'b1; ost_in = ST_DONE; oval_in = '0; olast_in = 1'b1;
               unique case (cmd.opcode)
                  OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT: begin
                     if (cmd.opcode == OP_INSERT && pos_c >= cnt_ff) begin
                        ost_in = ST_IGNORED;
                     end else if (full) begin
                        ost_in = ST_FULL;
                     end else if (cmd.opcode == OP_INSERT && pos_c != '0) begin
                        ov_in = 1'b0;
                        dir_in = (pos_c < half);
                        if (pos_c < half) begin
                           t_in = head_ff; steps_in = pos_c;
                        end else begin
                           t_in = tail_ff; steps_in = cnt_ff - 1'b1 - pos_c;
                        end
                     end else begin
                        vw_en = 1'b1;
                        used_in[free_slot] = 1'b1;
                        cnt_in = cnt_ff + 1'b1;
                        if (cnt_ff == '0) begin
                           head_in = free_slot; tail_in = free_slot;
                        end else if (cmd.opcode == OP_PUSH_BACK) begin
                           pw_en = 1'b1; pw_a = free_slot; pw_d = tail_ff;
                           nw_en = 1'b1; nw_a = tail_ff; nw_d = free_slot;
                           tail_in = free_slot;
                        end else begin
                           nw_en = 1'b1; nw_a = free_slot; nw_d = head_ff;
                           pw_en = 1'b1; pw_a = head_ff; pw_d = free_slot;
                           head_in = free_slot;
                        end
                     end
                  end
                  OP_POP_FRONT, OP_POP_BACK, OP_ERASE: begin
                     if (cnt_ff == '0 || (cmd.opcode == OP_ERASE && pos_c >= cnt_ff)) begin
                        ost_in = ST_IGNORED;
                     end else if (cmd.opcode == OP_POP_FRONT
                                  || (cmd.opcode == OP_ERASE && pos_c == '0)) begin
                        if (cnt_ff > CB'(1)) head_in = nxt_mem[head_ff];
                        used_in[head_ff] = 1'b0;
                        cnt_in = cnt_ff - 1'b1;
                     end else if (cmd.opcode == OP_POP_BACK || pos_c + 1'b1 == cnt_ff) begin
                        if (cnt_ff > CB'(1)) tail_in = prv_mem[tail_ff];
                        used_in[tail_ff] = 1'b0;
                        cnt_in = cnt_ff - 1'b1;
                     end else begin
                        ov_in = 1'b0;
                        dir_in = (pos_c < half);
                        if (pos_c < half) begin
                           t_in = head_ff; steps_in = pos_c;
                        end else begin
                           t_in = tail_ff; steps_in = cnt_ff - 1'b1 - pos_c;
                        end
                     end
                  end
                  OP_DUMP, OP_RDUMP: begin
                     if (cnt_ff == '0) begin
                        ost_in = ST_IGNORED;
                     end else begin
                        ov_in = 1'b0;
                        t_in = (cmd.opcode == OP_DUMP) ? head_ff : tail_ff;
                        steps_in = cnt_ff;
                     end
                  end
                  default: ;
               endcase
               ocnt_in = CNT_BITS'(cnt_in);
            end
         end
         BK_WALK: begin
            if (steps_ff != '0) begin
               t_in = dir_ff ? nxt_mem[t_ff] : prv_mem[t_ff];
               steps_in = steps_ff - 1'b1;
            end
         end
         BK_READP: begin
            p_in = prv_mem[t_ff];
         end
         BK_LINK: begin
            if (c_ff.opcode == OP_INSERT) begin
               vw_en = 1'b1;
               used_in[free_slot] = 1'b1;
               nw_en = 1'b1; nw_a = p_ff; nw_d = free_slot;
               pw_en = 1'b1; pw_a = t_ff; pw_d = free_slot;
               nw2_en = 1'b1; nw2_a = free_slot; nw2_d = t_ff;
               pw2_en = 1'b1; pw2_a = free_slot; pw2_d = p_ff;
               cnt_in = cnt_ff + 1'b1;
            end else begin
               nw_en = 1'b1; nw_a = p_ff; nw_d = nxt_mem[t_ff];
               pw_en = 1'b1; pw_a = nxt_mem[t_ff]; pw_d = p_ff;
               used_in[t_ff] = 1'b0;
               cnt_in = cnt_ff - 1'b1;
            end
         end
         BK_RESULT: begin
            if (out_free) begin
               ov_in = 1'b1; ost_in = ST_DONE; ocnt_in = CNT_BITS'(cnt_ff);
               oval_in = '0; olast_in = 1'b1;
            end
         end
         BK_DUMP: begin
            if (out_free) begin
               ov_in = 1'b1; ost_in = ST_DONE; ocnt_in = CNT_BITS'(cnt_ff);
               oval_in = ext_word; olast_in = (steps_ff == CB'(1));
               steps_in = steps_ff - 1'b1;
               t_in = (c_ff.opcode == OP_DUMP) ? nxt_mem[t_ff] : prv_mem[t_ff];
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         cnt_ff   <= '0;
         used_ff  <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         cnt_ff   <= cnt_in;
         used_ff  <= used_in;
         ov_ff    <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      c_ff     <= c_in;
      t_ff     <= t_in;
      p_ff     <= p_in;
      steps_ff <= steps_in;
      dir_ff   <= dir_in;
      ost_ff   <= ost_in;
      ocnt_ff  <= ocnt_in;
      oval_ff  <= oval_in;
      olast_ff <= olast_in;
   end

   always_ff @(posedge clock) begin
      if (vw_en)  val_mem[vw_a] <= WORD_BITS'($signed(c_in.item_value));
      if (nw_en)  nxt_mem[nw_a] <= nw_d;
      if (nw2_en) nxt_mem[nw2_a] <= nw2_d;
      if (pw_en)  prv_mem[pw_a] <= pw_d;
      if (pw2_en) prv_mem[pw2_a] <= pw2_d;
   end

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CB'(CAPACITY)) else $error("count above capacity");
   a_used_count: assert property (@(posedge clock) disable iff (reset)
      $countones(used_ff) == int'(cnt_ff)) else $error("slot map and count disagree");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      ov_ff && rsp_stall |=> ov_ff && $stable(oval_ff)) else $error("result lost");
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_take |-> state_ff == BK_IDLE) else $error("command taken while busy");
`endif

endmodule

// File: hw/rtl/indexed_double_ended_list.sv
// top level of the indexed double-ended list
// path: push, pop and end cases go through the command queue and the result register;
//   insert or erase inside the list also walks the links from the nearer end, then relinks
// throughput: one item per cycle for end operations while the receiver does not stall;
//   a dump gives one beat a cycle while the receiver does not stall
// reset: synchronous; list empties at once, link and value stores keep stale data
module indexed_double_ended_list
   import idel_pkg::*;
#(
   parameter int unsigned CAPACITY  = 32,
   parameter int unsigned WORD_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [2:0]           req_opcode,
   input  logic [POS_BITS-1:0]  req_position,
   input  logic signed [31:0]   req_item_value,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_status,
   output logic [CNT_BITS-1:0]  rsp_entry_count,
   output logic signed [31:0]   rsp_dump_value,
   output logic                 rsp_last_of_run
);

   cmd_type req_cmd, q_cmd;
   logic    q_valid, q_take;

   assign req_cmd.opcode     = opcode_type'(req_opcode);
   assign req_cmd.position   = req_position;
   assign req_cmd.item_value = req_item_value;

   idel_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (req_valid),
      .wr_stall (req_stall),
      .wr_cmd   (req_cmd),
      .rd_valid (q_valid),
      .rd_take  (q_take),
      .rd_cmd   (q_cmd)
   );

   idel_back #(
      .CAPACITY  (CAPACITY),
      .WORD_BITS (WORD_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (q_valid),
      .cmd_take        (q_take),
      .cmd             (q_cmd),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count),
      .rsp_dump_value  (rsp_dump_value),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

// File: tb/tb_top.sv
// self-checking testbench for the indexed double-ended list
`timescale 1ns / 100ps

module tb_top;
   import idel_pkg::*;

   localparam int CAP = 32;

   typedef struct packed {
      logic [1:0]  status;
      logic [6:0]  entry_count;
      logic [31:0] dump_value;
      logic        last_of_run;
   } beat_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [2:0] req_opcode = '0;
   logic [POS_BITS-1:0] req_position = '0;
   logic signed [31:0] req_item_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_status;
   logic [CNT_BITS-1:0] rsp_entry_count;
   logic signed [31:0] rsp_dump_value;
   logic rsp_last_of_run;

   indexed_double_ended_list uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_opcode(req_opcode),
      .req_position(req_position), .req_item_value(req_item_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_entry_count(rsp_entry_count), .rsp_dump_value(rsp_dump_value),
      .rsp_last_of_run(rsp_last_of_run)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // plain queue model of list contents, front at index 0
   logic [31:0] list_words[$];
   beat_t expected_beats[$];
   int errors = 0;
   int items_sent = 0;
   int beats_seen = 0;
   int hold_cycles = 0;
   bit random_stall = 1'b0;

   function automatic beat_t mk(logic [1:0] st, logic [31:0] v, bit last);
      beat_t b;
      b.status = st;
      b.entry_count = 7'(list_words.size());
      b.dump_value = v;
      b.last_of_run = last;
      return b;
   endfunction

   function automatic void predict_list_op(opcode_type op, int pos, logic [31:0] v);
      int n;
      logic [1:0] st;
      n = list_words.size();
      st = ST_DONE;
      case (op)
         OP_PUSH_FRONT: if (n >= CAP) st = ST_FULL; else list_words.insert(0, v);
         OP_PUSH_BACK: if (n >= CAP) st = ST_FULL; else list_words.insert(n, v);
         OP_POP_FRONT: if (n == 0) st = ST_IGNORED; else list_words.delete(0);
         OP_POP_BACK: if (n == 0) st = ST_IGNORED; else list_words.delete(n - 1);
         OP_INSERT: begin
            if (pos >= n) st = ST_IGNORED;
            else if (n >= CAP) st = ST_FULL;
            else list_words.insert(pos, v);
         end
         OP_ERASE: if (pos >= n) st = ST_IGNORED; else list_words.delete(pos);
         default: begin
            if (n == 0) begin
               expected_beats.insert(expected_beats.size(), mk(ST_IGNORED, '0, 1'b1));
            end else begin
               for (int i = 0; i < n; i++)
                  expected_beats.insert(expected_beats.size(), mk(ST_DONE,
                     list_words[(op == OP_DUMP) ? i : n - 1 - i], i == n - 1));
            end
            return;
         end
      endcase
      expected_beats.insert(expected_beats.size(), mk(st, '0, 1'b1));
   endfunction

   function automatic int short_gap();
      return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) :
             (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3));
   endfunction

   task automatic send_item(opcode_type op, int pos, logic [31:0] v, bit gaps = 1'b1);
      int g;
      req_valid <= 1'b1;
      req_opcode <= op;
      req_position <= POS_BITS'(pos);
      req_item_value <= v;
      predict_list_op(op, pos, v);
      items_sent++;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      g = gaps ? short_gap() : 0;
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      while (expected_beats.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (80) @(posedge clock);
   endtask

   // result checker
   always @(posedge clock) begin
      beat_t exp_b;
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_seen++;
         if (expected_beats.size() == 0) begin
            $display("%0t unexpected beat: status %0d count %0d value %h last %0d", $time,
               rsp_status, rsp_entry_count, rsp_dump_value, rsp_last_of_run);
            errors++;
         end else begin
            exp_b = expected_beats[0];
            expected_beats.delete(0);
            if (rsp_status !== exp_b.status) begin
               $display("%0t status: expected %0d actual %0d", $time, exp_b.status, rsp_status);
               errors++;
            end
            if (rsp_entry_count !== exp_b.entry_count) begin
               $display("%0t entry_count: expected %0d actual %0d", $time,
                  exp_b.entry_count, rsp_entry_count);
               errors++;
            end
            if (rsp_dump_value !== exp_b.dump_value) begin
               $display("%0t dump_value: expected %h actual %h", $time,
                  exp_b.dump_value, rsp_dump_value);
               errors++;
            end
            if (rsp_last_of_run !== exp_b.last_of_run) begin
               $display("%0t last_of_run: expected %0d actual %0d", $time,
                  exp_b.last_of_run, rsp_last_of_run);
               errors++;
            end
         end
      end
   end

   // receiver stall driver, with an optional long hold-off
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else if (random_stall) begin
         rsp_stall <= ($urandom_range(0, 3) == 0);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic test_empty_cases();
      send_item(OP_POP_FRONT, 0, 32'h0);
      send_item(OP_POP_BACK, 0, 32'h0);
      send_item(OP_INSERT, 0, 32'h1);
      send_item(OP_ERASE, 63, 32'h2);
      send_item(OP_DUMP, 0, 32'h0);
      send_item(OP_RDUMP, 0, 32'h0);
   endtask

   task automatic test_ends_and_positions();
      send_item(OP_PUSH_BACK, 0, 32'h7fff_ffff);
      send_item(OP_PUSH_FRONT, 0, 32'h8000_0000);
      send_item(OP_PUSH_BACK, 0, 32'hffff_ffff);
      send_item(OP_INSERT, 0, 32'h0);
      send_item(OP_INSERT, 2, 32'h1234_5678);
      send_item(OP_INSERT, 5, 32'h5);
      send_item(OP_DUMP, 0, 32'h0);
      send_item(OP_RDUMP, 0, 32'h0);
      send_item(OP_ERASE, 2, 32'h0);
      send_item(OP_ERASE, 0, 32'h0);
      send_item(OP_ERASE, 2, 32'h0);
      send_item(OP_POP_BACK, 0, 32'h0);
      send_item(OP_POP_FRONT, 0, 32'h0);
      send_item(OP_DUMP, 0, 32'h0);
   endtask

   task automatic test_full_list();
      while (list_words.size() < CAP) send_item(OP_PUSH_BACK, 0, $urandom(), 1'b0);
      send_item(OP_PUSH_FRONT, 0, 32'h1);
      send_item(OP_PUSH_BACK, 0, 32'h2);
      send_item(OP_INSERT, 5, 32'h3);
      send_item(OP_INSERT, 40, 32'h4);
      send_item(OP_DUMP, 0, 32'h0);
      send_item(OP_INSERT, 31, 32'h0);
      send_item(OP_ERASE, 31, 32'h0);
      send_item(OP_ERASE, 16, 32'h0);
      send_item(OP_INSERT, 30, 32'h0);
      send_item(OP_RDUMP, 0, 32'h0);
   endtask

   // long receiver hold-off while items keep coming
   task automatic test_backpressure();
      hold_cycles = 300;
      repeat (20) send_item(opcode_type'($urandom_range(0, 5)), $urandom_range(0, 33),
                            $urandom(), 1'b0);
      wait_drained();
   endtask

   task automatic test_random_mix(int n);
      int r;
      int sz;
      opcode_type op;
      random_stall = 1'b1;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         sz = list_words.size();
         if (r < 25) op = ($urandom_range(0, 1) != 0) ? OP_PUSH_BACK : OP_PUSH_FRONT;
         else if (r < 40) op = ($urandom_range(0, 1) != 0) ? OP_POP_BACK : OP_POP_FRONT;
         else if (r < 62) op = OP_INSERT;
         else if (r < 82) op = OP_ERASE;
         else op = ($urandom_range(0, 1) != 0) ? OP_DUMP : OP_RDUMP;
         send_item(op, ($urandom_range(0, 9) == 0 || sz == 0) ? $urandom_range(0, 63)
                       : $urandom_range(0, sz - 1), $urandom());
         if (i == n / 2) wait_drained();
      end
      random_stall = 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_cases();
      test_ends_and_positions();
      test_full_list();
      wait_drained();
      test_backpressure();
      test_random_mix(30);
      wait_drained();
      $display("covered %0d items and %0d result beats: end ops, insert, erase,", items_sent,
         beats_seen);
      $display("dumps both ways, empty and full list, long and random receiver stalls");
      if (errors == 0 && expected_beats.size() == 0) begin
         $display("[indexed_double_ended_list] OK");
      end else begin
         $display("[indexed_double_ended_list] ERROR");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("[indexed_double_ended_list] ERROR");
      $finish;
   end

endmodule
